// ===== sv/crr_pkg.sv =====
package crr_pkg;

  localparam int FIFO_DEPTH  = 23;
  localparam int CHUNK_BYTES = 16;
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam int ID_W    = 29;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int FAIL_W  = 16;
  localparam int OFF_W   = 32;
  localparam int WLEN_W  = 5;
  localparam int SIZE_W  = 32;
  localparam int PUSH_W  = 3;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 184;

  localparam logic [8:0] CRC_POLY = 9'h12F;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_NACK  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic REG_NODE_ID       = 1'b0;
  localparam logic REG_FIRMWARE_SIZE = 1'b1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic                valid;
    logic                match;
    logic                pass;
    logic [PUSH_W-1:0]   push_n;
    logic [55:0]         push_data;
  } frame_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [FAIL_W-1:0] fail_count;
    logic [OFF_W-1:0]  write_offset;
    logic [63:0]       write_low;
    logic [63:0]       write_high;
    logic [WLEN_W-1:0] write_len;
  } result_t;

  // Slot 0 is the reply, slot 1 the chunk write, slot 2 the tail write.
  typedef struct packed {
    logic             load;
    logic [2:0]       pend;
    result_t [2:0]    res;
  } bundle_t;

  // The remainder is linear in the word, so it is the XOR of the constant
  // remainders of those bit positions that are set.
  function automatic logic [7:0] crc_rem(input logic [DATA_W-1:0] w);
    logic [7:0] r;
    logic [7:0] p;
    r = '0;
    p = 8'h01;
    for (int b = 0; b < DATA_W; b++) begin
      if (w[b]) begin
        r = r ^ p;
      end
      p = {p[6:0], 1'b0} ^ (p[7] ? CRC_POLY[7:0] : 8'h00);
    end
    return r;
  endfunction

endpackage

// ===== sv/crr_check.sv =====
module crr_check
  import crr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [ID_W-1:0]       node_id,
  input  logic                  frm_ready,
  output frame_t                frm
);

  logic              valid_r, valid_nxt;
  logic [ID_W-1:0]   fid_r;
  logic [LEN_W-1:0]  len_r;
  logic [DATA_W-1:0] data_r;

  logic [LEN_W-1:0]  lenc;
  logic [DATA_W-1:0] word;
  logic              match;
  logic              pass;

  assign in_tready = !valid_r || frm_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (frm_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      fid_r  <= in_tdata[ID_W-1:0];
      len_r  <= in_tdata[ID_W+LEN_W-1:ID_W];
      data_r <= in_tdata[ID_W+LEN_W+DATA_W-1:ID_W+LEN_W];
    end
  end

  // Lengths above eight count as eight.
  assign lenc = (len_r > LEN_W'(8)) ? LEN_W'(8) : len_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word[i*8 +: 8] = (LEN_W'(i) < lenc) ? data_r[i*8 +: 8] : 8'h00;
    end
  end

  assign match = (fid_r == node_id);
  assign pass  = (crc_rem(word) == 8'h00);

  always_comb begin
    frm.valid     = valid_r;
    frm.match     = match;
    frm.pass      = pass;
    frm.push_n    = (match && pass && lenc != '0) ? PUSH_W'(lenc - LEN_W'(1)) : '0;
    frm.push_data = data_r[55:0];
  end

endmodule

// ===== sv/crr_core.sv =====
module crr_core
  import crr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  frame_t            frm,
  output logic              frm_ready,
  input  logic [SIZE_W-1:0] firmware_size,
  input  logic              bundle_free,
  output bundle_t           bundle
);

  byte_t             fifo_r [FIFO_DEPTH];
  logic [CNT_W-1:0]  count_r;
  logic [OFF_W-1:0]  bw_r;
  logic [FAIL_W-1:0] err_r;

  byte_t             fifo1 [FIFO_DEPTH];
  byte_t             fifo2 [FIFO_DEPTH];
  byte_t             fifo_nxt [FIFO_DEPTH];
  logic [CNT_W-1:0]  room, push_ext, acc_n, k;
  logic [CNT_W-1:0]  count1, count2, count_nxt;
  logic [OFF_W-1:0]  bw2, bw_nxt;
  logic [FAIL_W-1:0] err_nxt;
  logic              chunk, tail, advance;
  logic [WLEN_W-1:0] tn;
  logic [63:0]       chunk_lo, chunk_hi, tail_lo, tail_hi;

  assign frm_ready = bundle_free;
  assign advance   = frm.valid && bundle_free;

  // Entries are kept packed from index zero, so a pop is a shift.
  always_comb begin
    room     = CNT_W'(FIFO_DEPTH) - count_r;
    push_ext = CNT_W'(frm.push_n);
    acc_n    = (push_ext > room) ? room : push_ext;
    k        = '0;
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      fifo1[i] = fifo_r[i];
      k = CNT_W'(i) - count_r;
      if (CNT_W'(i) >= count_r && k < acc_n) begin
        fifo1[i] = frm.push_data[{k[2:0], 3'b000} +: 8];
      end
    end
    count1 = count_r + acc_n;
  end

  assign chunk = (count1 >= CNT_W'(CHUNK_BYTES));

  always_comb begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      fifo2[i] = fifo1[i];
      if (i + CHUNK_BYTES < FIFO_DEPTH) begin
        if (chunk) begin
          fifo2[i] = fifo1[i + CHUNK_BYTES];
        end
      end
    end
    count2 = chunk ? count1 - CNT_W'(CHUNK_BYTES) : count1;
    bw2    = bw_r + (chunk ? OFF_W'(CHUNK_BYTES) : '0);
  end

  // The tail compare is done one bit wider so that it never wraps.
  assign tail = (({1'b0, bw2} + (OFF_W+1)'(CHUNK_BYTES)) > {1'b0, firmware_size})
                && (count2 != '0);

  always_comb begin
    tn = '0;
    if (tail) begin
      tn = (count2 > CNT_W'(CHUNK_BYTES)) ? WLEN_W'(CHUNK_BYTES) : WLEN_W'(count2);
    end
    count_nxt = count2 - CNT_W'(tn);
    bw_nxt    = bw2 + OFF_W'(tn);
    err_nxt   = err_r + ((frm.match && !frm.pass) ? FAIL_W'(1) : '0);
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      fifo_nxt[i] = fifo2[i];
      for (int s = 1; s <= CHUNK_BYTES; s++) begin
        if (i + s < FIFO_DEPTH) begin
          if (tn == WLEN_W'(s)) begin
            fifo_nxt[i] = fifo2[i + s];
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chunk_lo[i*8 +: 8] = fifo1[i];
      chunk_hi[i*8 +: 8] = fifo1[i + 8];
      tail_lo[i*8 +: 8]  = (WLEN_W'(i) < tn) ? fifo2[i] : 8'h00;
      tail_hi[i*8 +: 8]  = (WLEN_W'(i + 8) < tn) ? fifo2[i + 8] : 8'h00;
    end
  end

  always_comb begin
    bundle.load = advance;
    bundle.pend = {tail, chunk, frm.match};

    bundle.res[0].kind         = frm.pass ? KIND_ACK : KIND_NACK;
    bundle.res[0].fail_count   = frm.pass ? '0 : err_r;
    bundle.res[0].write_offset = '0;
    bundle.res[0].write_low    = '0;
    bundle.res[0].write_high   = '0;
    bundle.res[0].write_len    = '0;

    bundle.res[1].kind         = KIND_WRITE;
    bundle.res[1].fail_count   = '0;
    bundle.res[1].write_offset = bw_r;
    bundle.res[1].write_low    = chunk_lo;
    bundle.res[1].write_high   = chunk_hi;
    bundle.res[1].write_len    = WLEN_W'(CHUNK_BYTES);

    bundle.res[2].kind         = KIND_WRITE;
    bundle.res[2].fail_count   = '0;
    bundle.res[2].write_offset = bw2;
    bundle.res[2].write_low    = tail_lo;
    bundle.res[2].write_high   = tail_hi;
    bundle.res[2].write_len    = tn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bw_r    <= '0;
      err_r   <= '0;
    end else if (advance) begin
      count_r <= count_nxt;
      bw_r    <= bw_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fifo_r <= fifo_nxt;
    end
  end

endmodule

// ===== sv/crr_out.sv =====
module crr_out
  import crr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  bundle_t                bundle,
  output logic                   bundle_free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  logic [2:0]    pend_r, pend_nxt;
  result_t [2:0] res_r;
  result_t       sel;
  logic          last;
  logic          take;

  assign out_tvalid  = (pend_r != 3'b000);
  assign take        = out_tvalid && out_tready;
  // Exactly one request left means this beat closes the frame's results.
  assign last        = ((pend_r & (pend_r - 3'd1)) == 3'b000);
  assign bundle_free = !out_tvalid || (take && last);

  always_comb begin
    if (pend_r[0]) begin
      sel = res_r[0];
    end else if (pend_r[1]) begin
      sel = res_r[1];
    end else begin
      sel = res_r[2];
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (bundle.load) begin
      pend_nxt = bundle.pend;
    end else if (take) begin
      pend_nxt = pend_r & (pend_r - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'b000;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle.load) begin
      res_r <= bundle.res;
    end
  end

  assign out_tdata = {3'b000, sel.write_len, sel.write_high, sel.write_low,
                      sel.write_offset, sel.fail_count};
  assign out_tuser = sel.kind;
  assign out_tlast = last;

endmodule

// ===== sv/can_reflash_receiver.sv =====
// Channel   Direction  Payload
// in_*      slave      tdata: frame_id[28:0], data_len[32:29], frame_data[96:33]
// out_*     master     tdata: fail_count, write_offset, write_low, write_high, write_len
//                      tuser: kind; tlast: final result of a frame
// cfg_*     slave      cfg_index selects the register, cfg_data is the value
//
// A frame waits in the input register, where its check runs, and its results
// leave from the output register one per cycle while out_tready is high, from
// the cycle after the frame leaves the input register. A frame yields up to
// three results, and they share the single result port.
// Reset clears control state and counters; the byte buffer holds no reset value.
// A stall on the result side holds the input register and then in_tready.
module can_reflash_receiver
  import crr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // frame_id, data_len, frame_data, zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // fail_count, write_offset, write_low,
                                             // write_high, write_len, zero pad
  output logic [1:0]             out_tuser,  // kind
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data
);

  logic [ID_W-1:0]   node_id_r;
  logic [SIZE_W-1:0] fw_size_r;
  frame_t            frm;
  logic              frm_ready;
  bundle_t           bundle;
  logic              bundle_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= '0;
      fw_size_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NODE_ID:       node_id_r <= cfg_data[ID_W-1:0];
        REG_FIRMWARE_SIZE: fw_size_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  crr_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .node_id   (node_id_r),
    .frm_ready (frm_ready),
    .frm       (frm)
  );

  crr_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .frm           (frm),
    .frm_ready     (frm_ready),
    .firmware_size (fw_size_r),
    .bundle_free   (bundle_free),
    .bundle        (bundle)
  );

  crr_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .bundle      (bundle),
    .bundle_free (bundle_free),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== verif/tb.sv =====
module tb;
  import crr_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int SETTLE_TICKS = 8;
  localparam int NACK_STORM   = 12;

  typedef struct packed {
    logic [1:0]        kind;
    logic [FAIL_W-1:0] fail_count;
    logic [OFF_W-1:0]  write_offset;
    logic [63:0]       write_low;
    logic [63:0]       write_high;
    logic [WLEN_W-1:0] write_len;
    logic              last;
  } flash_reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // frame_id, data_len, frame_data, zero pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // fail_count, write_offset, write_low,
                                           // write_high, write_len, zero pad
  logic [1:0]             out_tuser;       // kind
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = 1'b0;
  logic [SIZE_W-1:0]      cfg_data = '0;

  can_reflash_receiver DUT (.*);

  // Remainder of the word after long division by the CRC polynomial.
  function automatic logic [7:0] poly_residue(input logic [63:0] w);
    for (int b = 63; b >= 8; b--) begin
      if (w[b]) begin
        w = w ^ ({55'd0, CRC_POLY} << (b - 8));
      end
    end
    return w[7:0];
  endfunction

  class reflash_scoreboard;
    logic [ID_W-1:0]   node_id;
    logic [SIZE_W-1:0] image_size;
    byte_t             held [FIFO_DEPTH];
    int unsigned       head;
    int unsigned       count;
    logic [OFF_W-1:0]  written;
    logic [FAIL_W-1:0] nack_count;
    flash_reply_t      replies_due [$];
    int unsigned       frames_seen, errors, acks, nacks, writes, tails;

    function new();
      node_id = '0;
      image_size = '0;
      head = 0;
      count = 0;
      written = '0;
      nack_count = '0;
      frames_seen = 0;
      errors = 0;
      acks = 0;
      nacks = 0;
      writes = 0;
      tails = 0;
    endfunction

    function void set_reg(logic idx, logic [SIZE_W-1:0] value);
      if (idx == REG_NODE_ID) begin
        node_id = value[ID_W-1:0];
      end else begin
        image_size = value;
      end
    endfunction

    function void queue_result(logic [1:0] k, logic [FAIL_W-1:0] fc, logic [OFF_W-1:0] off,
                               logic [63:0] lo, logic [63:0] hi, logic [WLEN_W-1:0] wl);
      flash_reply_t r;
      r.kind = k;
      r.fail_count = fc;
      r.write_offset = off;
      r.write_low = lo;
      r.write_high = hi;
      r.write_len = wl;
      r.last = 1'b0;
      replies_due.push_back(r);
    endfunction

    function void emit_write(int unsigned n);
      logic [127:0] chunk;
      chunk = '0;
      for (int i = 0; i < n; i++) begin
        chunk[8*i +: 8] = held[head];
        head = (head + 1) % FIFO_DEPTH;
        count--;
      end
      queue_result(KIND_WRITE, '0, written, chunk[63:0], chunk[127:64], n[WLEN_W-1:0]);
      written = written + n;
    endfunction

    function void take_frame(logic [ID_W-1:0] fid, logic [LEN_W-1:0] len_in,
                             logic [DATA_W-1:0] data);
      int unsigned  len;
      int           queued_before;
      logic [63:0]  word;
      len = (len_in > 8) ? 8 : len_in;
      queued_before = replies_due.size();
      frames_seen++;
      if (fid == node_id) begin
        word = (len >= 8) ? data : data & ((64'd1 << (8 * len)) - 64'd1);
        if (poly_residue(word) == 8'h00) begin
          // The last byte of a frame is its check byte and is not buffered.
          for (int i = 0; i + 1 < int'(len); i++) begin
            if (count < FIFO_DEPTH) begin
              held[(head + count) % FIFO_DEPTH] = data[8*i +: 8];
              count++;
            end
          end
          queue_result(KIND_ACK, '0, '0, '0, '0, '0);
        end else begin
          queue_result(KIND_NACK, nack_count, '0, '0, '0, '0);
          nack_count = nack_count + 1'b1;
        end
      end
      if (count >= CHUNK_BYTES) begin
        emit_write(CHUNK_BYTES);
      end
      if (({1'b0, written} + 33'd16) > {1'b0, image_size} && count > 0) begin
        emit_write((count > CHUNK_BYTES) ? CHUNK_BYTES : count);
      end
      if (replies_due.size() > queued_before) begin
        replies_due[$].last = 1'b1;
      end
    endfunction

    function string describe(flash_reply_t r);
      return $sformatf("kind %0d fail %h off %h lo %h hi %h len %0d last %0d", r.kind,
                       r.fail_count, r.write_offset, r.write_low, r.write_high, r.write_len,
                       r.last);
    endfunction

    function void compare_result(logic [1:0] kind, logic [OUT_TDATA_W-1:0] td, logic last);
      flash_reply_t got;
      flash_reply_t want;
      got.kind = kind;
      got.fail_count = td[15:0];
      got.write_offset = td[47:16];
      got.write_low = td[111:48];
      got.write_high = td[175:112];
      got.write_len = td[180:176];
      got.last = last;
      if (replies_due.size() == 0) begin
        if (errors < 10) begin
          $display("unexpected result: %s", describe(got));
        end
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (got !== want) begin
        if (errors < 10) begin
          $display("mismatch: expected %s", describe(want));
          $display("          actual   %s", describe(got));
        end
        errors++;
      end else if (want.kind == KIND_ACK) begin
        acks++;
      end else if (want.kind == KIND_NACK) begin
        nacks++;
      end else begin
        writes++;
        if (want.write_len < CHUNK_BYTES) begin
          tails++;
        end
      end
    endfunction
  endclass

  reflash_scoreboard sb;
  int unsigned       frames_sent = 0;
  int unsigned       cycle_count = 0;
  logic [ID_W-1:0]   cur_id = '0;
  logic              rx_open = 1'b0;
  logic [15:0]       stall_pat = 16'hFFFF;
  logic [5:0]        pat_age = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver follows a rotating stall mask that is reloaded whenever pat_age wraps to zero.
  always @(posedge clk) begin
    pat_age <= pat_age + 1'b1;
    if (pat_age == '0) begin
      if ($urandom_range(0, 3) == 0) begin
        stall_pat <= 16'hFFFF;
      end else begin
        stall_pat <= 16'($urandom) | 16'h8001;
      end
    end else begin
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    end
    out_tready <= rx_open | stall_pat[15];
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      sb.set_reg(cfg_index, cfg_data);
    end
    if (rst_n && in_tvalid && in_tready) begin
      sb.take_frame(in_tdata[28:0], in_tdata[32:29], in_tdata[96:33]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.compare_result(out_tuser, out_tdata, out_tlast);
    end
  end

  // Fills in the check byte so that the first len bytes divide evenly.
  function automatic logic [63:0] passing_data(int unsigned len, logic [63:0] raw);
    logic [63:0] mask;
    if (len == 0) begin
      return raw;
    end
    mask = (len >= 8) ? '1 : (64'd1 << (8 * len)) - 64'd1;
    for (int b = 0; b < 256; b++) begin
      raw[8*(len-1) +: 8] = b[7:0];
      if (poly_residue(raw & mask) == 8'h00) begin
        return raw;
      end
    end
    return raw;
  endfunction

  task automatic send_frame(input logic [ID_W-1:0] fid, input logic [LEN_W-1:0] len,
                            input logic [DATA_W-1:0] data);
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, data, len, fid};
    do @(posedge clk); while (!in_tready);
    frames_sent++;
  endtask

  task automatic idle_input(input int unsigned n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stops sending until every request has been seen and answered, then lets a
  // frame that yields nothing leave the pipeline.
  task automatic await_quiet();
    in_tvalid <= 1'b0;
    while (sb.frames_seen != frames_sent || sb.replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic program_regs(input logic [ID_W-1:0] id, input logic [SIZE_W-1:0] size);
    cfg_valid <= 1'b1;
    cfg_index <= REG_NODE_ID;
    cfg_data <= {3'd0, id};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_FIRMWARE_SIZE;
    cfg_data <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_id = id;
  endtask

  task automatic random_frames(input int unsigned n);
    int unsigned     sel;
    int unsigned     len;
    int unsigned     burst;
    int unsigned     gap;
    logic [ID_W-1:0] fid;
    logic [63:0]     data;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      len = $urandom_range(0, 8);
      data = {$urandom, $urandom};
      fid = cur_id;
      if (sel < 70) begin
        data = passing_data(len, data);
      end else if (sel < 80) begin
        // A single flipped bit inside the valid bytes must always fail.
        data = passing_data(len, data);
        if (len > 0) begin
          data = data ^ (64'd1 << $urandom_range(0, 8 * len - 1));
        end
      end else if (sel < 90) begin
        fid = ID_W'($urandom);
        if (fid == cur_id) begin
          fid = fid ^ 29'd1;
        end
      end else begin
        len = $urandom_range(9, 15);
        if (sel < 95) begin
          data = passing_data(8, data);
        end
      end
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          idle_input(gap);
        end
        burst = $urandom_range(1, 10);
        if ($urandom_range(0, 24) == 0) begin
          await_quiet();
        end
      end
      burst--;
      send_frame(fid, len[LEN_W-1:0], data);
    end
  endtask

  initial begin
    logic [63:0] d;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With a zero image size every frame flushes whatever it buffered.
    program_regs(29'd0, 32'd0);
    send_frame(29'd0, 4'd0, {$urandom, $urandom});
    send_frame(29'd0, 4'd1, 64'h0);
    send_frame(29'd0, 4'd1, 64'hFF);
    for (int n = 2; n <= 8; n++) begin
      send_frame(29'd0, n[3:0], passing_data(n, {$urandom, $urandom}));
    end
    send_frame(29'd0, 4'd8, passing_data(8, '1));
    send_frame(29'd0, 4'd9, passing_data(8, {$urandom, $urandom}));
    send_frame(29'd0, 4'd15, passing_data(8, '1));
    send_frame(29'h1FFF_FFFF, 4'd8, {$urandom, $urandom});
    send_frame(29'd0, 4'd8, '1);
    send_frame(29'd0, 4'd8, 64'd0);
    send_frame(29'd0, 4'd7, passing_data(7, 64'd0));
    await_quiet();

    // A huge image size leaves only full chunk writes.
    program_regs(ID_W'($urandom), 32'hFFFF_FFFF);
    random_frames(110);
    await_quiet();

    // Shrinking the size makes even a foreign frame flush the leftover bytes.
    program_regs(cur_id, 32'd0);
    send_frame(cur_id ^ 29'd1, 4'd8, {$urandom, $urandom});
    await_quiet();

    // Chunk writes first, then tail writes once the end of the image is near.
    program_regs(29'h1FFF_FFFF, sb.written + 32'd150);
    random_frames(110);
    await_quiet();

    // A run of failing frames back to back with the receiver always ready.
    rx_open <= 1'b1;
    for (int i = 0; i < NACK_STORM; i++) begin
      d = {$urandom, $urandom};
      d[7:0] = 8'($urandom_range(1, 255));
      send_frame(cur_id, 4'd1, d);
    end
    await_quiet();
    rx_open <= 1'b0;

    program_regs(ID_W'($urandom), sb.written + 32'($urandom_range(0, 300)));
    random_frames(110);
    await_quiet();

    $display("Sent %0d frames; checked %0d ACK, %0d NACK and %0d flash writes (%0d short).",
             sb.frames_seen, sb.acks, sb.nacks, sb.writes, sb.tails);
    $display("Image offset reached %0d bytes; error counter ended at %0d.",
             sb.written, sb.nack_count);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", sb.errors,
               sb.replies_due.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== can_reflash_receiver.f =====
sv/crr_pkg.sv
sv/crr_check.sv
sv/crr_core.sv
sv/crr_out.sv
sv/can_reflash_receiver.sv
verif/tb.sv
